// File: rtl/sbmd_pkg.sv
package sbmd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int CHW   = $clog2(MAX_HEIGHT + 1);
    localparam int OCW   = $clog2(MAX_WIDTH / 2 + 1);
    localparam int OCHW  = $clog2(MAX_HEIGHT / 2 + 1);
    localparam int SLOT_W = $clog2(LINE_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRGB_MODE     = 2'd2;

    localparam int SUM_W   = 20;
    localparam int ASUM_W  = 12;
    localparam int RECIP_W = 25;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int THR_W   = 31;
    localparam int LV_W    = 30;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 16;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int ENC_STAGES  = 8;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       last_of_level;
    } out_item_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [2:0][15:0]  color;
        logic [7:0]        alpha;
        logic [SLOT_W-1:0] slot;
        logic              first;
        logic              last;
        logic [3:0]        cnt;
        logic              mode;
        logic              level_end;
    } mid_item_t;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] color;
        logic [ASUM_W-1:0]     alpha;
    } line_entry_t;

    typedef logic [15:0]      fwd_tab_t [256];
    typedef logic [THR_W-1:0] thr_tab_t [256];

    localparam logic [RECIP_W-1:0] RECIP_TAB [10] = '{
        25'd0, 25'd16777216, 25'd8388608, 25'd5592405, 25'd4194304,
        25'd3355443, 25'd2796203, 25'd2396745, 25'd2097152, 25'd1864135
    };

    function automatic logic [63:0] pow5_q30(input logic [63:0] y);
        logic [63:0] p;
        p = (y * y) >> 30;
        p = (p * y) >> 30;
        p = (p * y) >> 30;
        return (p * y) >> 30;
    endfunction

    // sRGB value h/510 to linear light, Q2.30
    function automatic logic [63:0] decode_q30(input logic [63:0] h);
        logic [63:0] num;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (h <= 64'd20) begin
            num = (h * 64'd10) << 30;
            return (num * 64'd2 + 64'd65892) / 64'd131784;
        end
        t = (((h * 64'd1000 + 64'd28050) << 30) + 64'd269025) / 64'd538050;
        if (t > (64'd1 << 30)) begin
            t = 64'd1 << 30;
        end
        t2 = (t * t) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (pow5_q30(mid) <= t2) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return (t2 * lo) >> 30;
    endfunction

    function automatic fwd_tab_t build_fwd();
        fwd_tab_t    tab;
        logic [63:0] q;
        for (int v = 0; v < 256; v++) begin
            q = (decode_q30(64'(2 * v)) + 64'd8192) >> 14;
            tab[v] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
        return tab;
    endfunction

    function automatic thr_tab_t build_thr();
        thr_tab_t    tab;
        logic [63:0] d;
        tab[0] = '0;
        for (int v = 1; v < 256; v++) begin
            d = decode_q30(64'(2 * v - 1));
            tab[v] = d[THR_W-1:0];
        end
        return tab;
    endfunction

    localparam fwd_tab_t FWD_TAB = build_fwd();
    // decision levels between adjacent sRGB bytes
    localparam thr_tab_t THR_TAB = build_thr();

endpackage

// File: rtl/sbmd_ram.sv
module sbmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/sbmd_front.sv
module sbmd_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [sbmd_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [sbmd_pkg::CFG_DATA_W-1:0]    wr_data,
    input  logic                               push,
    input  sbmd_pkg::in_item_t                 in_item,
    input  logic                               q_full,
    output logic                               q_wr,
    output sbmd_pkg::mid_item_t                q_item
);
    import sbmd_pkg::*;

    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic                  mode_reg;
    logic [CW-1:0]   scol_reg, scol_next, xb_reg, xb_next, xe_reg, xe_next;
    logic [CHW-1:0]  srow_reg, srow_next, yb_reg, yb_next, ye_reg, ye_next;
    logic [OCW-1:0]  ocol_reg, ocol_next, xf_reg, xf_next;
    logic [OCHW-1:0] orow_reg, orow_next, yf_reg, yf_next;
    logic row_start_reg, row_start_next, lvl_start_reg, lvl_start_next;

    logic [CW-1:0]   w, xb_e, xe_e, xe_adv, scol_inc;
    logic [CHW-1:0]  h, yb_e, ye_e, ye_adv, srow_inc;
    logic [OCW-1:0]  ow, xf_e, xf_sum, xf_adv;
    logic [OCHW-1:0] oh, yf_e, yf_sum, yf_adv;
    logic [1:0]      qx, qy;
    logic            rx, ry;
    logic            cfg_hit, accept;
    logic [1:0]      span_x, span_y;

    assign cfg_hit = wr_en && (wr_index == REG_SOURCE_WIDTH || wr_index == REG_SOURCE_HEIGHT
                               || wr_index == REG_SRGB_MODE);
    assign accept  = push && !q_full;

    always_comb
    begin
        if (width_reg == '0)
            w = CW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w = CW'(MAX_WIDTH);
        else
            w = CW'(width_reg);
        if (height_reg == '0)
            h = CHW'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h = CHW'(MAX_HEIGHT);
        else
            h = CHW'(height_reg);

        ow = ((w >> 1) == '0) ? OCW'(1) : OCW'(w >> 1);
        oh = ((h >> 1) == '0) ? OCHW'(1) : OCHW'(h >> 1);

        // span step: size = q*osize + r, r kept below osize
        if (w == CW'(1))
        begin
            qx = 2'd1;
            rx = 1'b0;
        end
        else if (w[0] && ow == OCW'(1))
        begin
            qx = 2'd3;
            rx = 1'b0;
        end
        else
        begin
            qx = 2'd2;
            rx = w[0];
        end
        if (h == CHW'(1))
        begin
            qy = 2'd1;
            ry = 1'b0;
        end
        else if (h[0] && oh == OCHW'(1))
        begin
            qy = 2'd3;
            ry = 1'b0;
        end
        else
        begin
            qy = 2'd2;
            ry = h[0];
        end

        xb_e = row_start_reg ? '0 : xb_reg;
        xe_e = row_start_reg ? CW'(qx) : xe_reg;
        xf_e = row_start_reg ? OCW'(rx) : xf_reg;
        yb_e = lvl_start_reg ? '0 : yb_reg;
        ye_e = lvl_start_reg ? CHW'(qy) : ye_reg;
        yf_e = lvl_start_reg ? OCHW'(ry) : yf_reg;

        // next span end, Bresenham style
        xf_sum = xf_e + OCW'(rx);
        xe_adv = xe_e + CW'(qx) + CW'(xf_sum == ow);
        xf_adv = (xf_sum == ow) ? '0 : xf_sum;
        yf_sum = yf_e + OCHW'(ry);
        ye_adv = ye_e + CHW'(qy) + CHW'(yf_sum == oh);
        yf_adv = (yf_sum == oh) ? '0 : yf_sum;

        scol_inc = scol_reg + CW'(1);
        srow_inc = srow_reg + CHW'(1);
        span_x   = 2'(xe_e - xb_e);
        span_y   = 2'(ye_e - yb_e);
    end

    always_comb
    begin
        scol_next      = scol_reg;
        srow_next      = srow_reg;
        ocol_next      = ocol_reg;
        orow_next      = orow_reg;
        xb_next        = xb_reg;
        xe_next        = xe_reg;
        xf_next        = xf_reg;
        yb_next        = yb_reg;
        ye_next        = ye_reg;
        yf_next        = yf_reg;
        row_start_next = row_start_reg;
        lvl_start_next = lvl_start_reg;
        if (cfg_hit)
        begin
            scol_next      = '0;
            srow_next      = '0;
            ocol_next      = '0;
            orow_next      = '0;
            row_start_next = 1'b1;
            lvl_start_next = 1'b1;
        end
        else if (accept)
        begin
            row_start_next = 1'b0;
            lvl_start_next = 1'b0;
            yb_next        = yb_e;
            ye_next        = ye_e;
            yf_next        = yf_e;
            scol_next      = scol_inc;
            if (scol_inc == xe_e)
            begin
                ocol_next = ocol_reg + OCW'(1);
                xb_next   = xe_e;
                xe_next   = xe_adv;
                xf_next   = xf_adv;
            end
            else
            begin
                xb_next = xb_e;
                xe_next = xe_e;
                xf_next = xf_e;
            end
            if (scol_inc == w)
            begin
                scol_next      = '0;
                ocol_next      = '0;
                row_start_next = 1'b1;
                srow_next      = srow_inc;
                if (srow_inc == ye_e)
                begin
                    orow_next = orow_reg + OCHW'(1);
                    yb_next   = ye_e;
                    ye_next   = ye_adv;
                    yf_next   = yf_adv;
                end
                if (srow_inc == h)
                begin
                    srow_next      = '0;
                    orow_next      = '0;
                    lvl_start_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= CFG_DATA_W'(1);
            height_reg    <= CFG_DATA_W'(1);
            mode_reg      <= 1'b0;
            scol_reg      <= '0;
            srow_reg      <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            xb_reg        <= '0;
            xe_reg        <= '0;
            xf_reg        <= '0;
            yb_reg        <= '0;
            ye_reg        <= '0;
            yf_reg        <= '0;
            row_start_reg <= 1'b1;
            lvl_start_reg <= 1'b1;
        end
        else
        begin
            if (wr_en && wr_index == REG_SOURCE_WIDTH)
                width_reg <= wr_data;
            if (wr_en && wr_index == REG_SOURCE_HEIGHT)
                height_reg <= wr_data;
            if (wr_en && wr_index == REG_SRGB_MODE)
                mode_reg <= wr_data[0];
            scol_reg      <= scol_next;
            srow_reg      <= srow_next;
            ocol_reg      <= ocol_next;
            orow_reg      <= orow_next;
            xb_reg        <= xb_next;
            xe_reg        <= xe_next;
            xf_reg        <= xf_next;
            yb_reg        <= yb_next;
            ye_reg        <= ye_next;
            yf_reg        <= yf_next;
            row_start_reg <= row_start_next;
            lvl_start_reg <= lvl_start_next;
        end
    end

    always_comb
    begin
        q_wr = accept;
        q_item.color[0]  = mode_reg ? FWD_TAB[in_item.red_in]   : {8'd0, in_item.red_in};
        q_item.color[1]  = mode_reg ? FWD_TAB[in_item.green_in] : {8'd0, in_item.green_in};
        q_item.color[2]  = mode_reg ? FWD_TAB[in_item.blue_in]  : {8'd0, in_item.blue_in};
        q_item.alpha     = in_item.alpha_in;
        q_item.slot      = ocol_reg[SLOT_W-1:0];
        q_item.first     = (scol_reg == xb_e) && (srow_reg == yb_e);
        q_item.last      = (scol_inc == xe_e) && (srow_inc == ye_e);
        q_item.cnt       = 4'(span_x * span_y);
        q_item.mode      = mode_reg;
        q_item.level_end = ((ocol_reg + OCW'(1)) == ow) && ((orow_reg + OCHW'(1)) == oh);
    end

    assert property (@(posedge clk) disable iff (!rst_n) xb_e < xe_e && yb_e < ye_e)
        else $error("empty span");
    assert property (@(posedge clk) disable iff (!rst_n) scol_reg < w && srow_reg < h)
        else $error("raster position past level");

endmodule

// File: rtl/sbmd_queue.sv
module sbmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  sbmd_pkg::mid_item_t wr_item,
    output logic                full,
    input  logic                rd_en,
    output sbmd_pkg::mid_item_t rd_item,
    output logic                empty
);
    import sbmd_pkg::*;

    mid_item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wp_reg, rp_reg;
    logic [QPTR_W:0]       cnt_reg, cnt_next;
    logic                  do_wr, do_rd;

    assign full    = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + (QPTR_W + 1)'(do_wr) - (QPTR_W + 1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + QPTR_W'(1);
            if (do_rd)
                rp_reg <= rp_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count overrun");

endmodule

// File: rtl/sbmd_back.sv
module sbmd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  sbmd_pkg::mid_item_t q_item,
    output logic                q_rd,
    output logic                empty,
    input  logic                pop,
    output sbmd_pkg::out_item_t out_item
);
    import sbmd_pkg::*;

    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic                  last;
        logic [2:0][LV_W-1:0]  lv;
        logic [2:0][7:0]       code;
        logic [2:0][7:0]       lin;
        logic [7:0]            alpha;
    } enc_t;

    localparam int RES_W = $clog2(OUT_DEPTH + 1);

    // accumulate stage
    logic        s1_valid_reg;
    mid_item_t   s1_reg;
    line_entry_t rd_entry, old_entry, acc_entry;
    logic        wb_valid_reg;
    logic [SLOT_W-1:0] wb_slot_reg;
    line_entry_t wb_data_reg;

    // multiply stage
    logic                    s2_valid_reg, s2_mode_reg, s2_last_reg;
    line_entry_t             s2_sums_reg;
    logic [3:0]              s2_cnt_reg;
    logic                    s3_valid_reg, s3_mode_reg, s3_last_reg;
    logic [3:0][PROD_W-1:0]  s3_prod_reg;

    enc_t enc_reg  [ENC_STAGES+1];
    enc_t enc0;
    enc_t enc_next [1:ENC_STAGES];

    out_item_t         fifo_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] fwp_reg, frp_reg;
    logic [OPTR_W:0]   fcnt_reg;
    logic [RES_W-1:0]  res_reg;
    logic              fifo_push, fifo_pop, drop;
    out_item_t         push_item;

    assign q_rd      = !q_empty && (res_reg < RES_W'(OUT_DEPTH));
    assign drop      = s1_valid_reg && !s1_reg.last;
    assign fifo_push = enc_reg[ENC_STAGES].valid;
    assign fifo_pop  = pop && !empty;
    assign empty     = (fcnt_reg == '0);
    assign out_item  = fifo_reg[frp_reg];

    sbmd_ram #(
        .WIDTH ($bits(line_entry_t)),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_reg.slot),
        .wr_data (acc_entry),
        .rd_en   (q_rd),
        .rd_addr (q_item.slot),
        .rd_data (rd_entry)
    );

    // read-modify-write with bypass of the previous cycle's write
    always_comb
    begin
        old_entry = (wb_valid_reg && wb_slot_reg == s1_reg.slot) ? wb_data_reg : rd_entry;
        for (int c = 0; c < 3; c++)
        begin
            acc_entry.color[c] = (s1_reg.first ? '0 : old_entry.color[c])
                                 + SUM_W'(s1_reg.color[c]);
        end
        acc_entry.alpha = (s1_reg.first ? '0 : old_entry.alpha) + ASUM_W'(s1_reg.alpha);
    end

    // rounded mean, then start of the encode search
    always_comb
    begin
        logic [PROD_W:0] rnd;
        logic [PROD_W-24:0] m;
        logic [15:0] m16;
        enc0.valid = s3_valid_reg;
        enc0.mode  = s3_mode_reg;
        enc0.last  = s3_last_reg;
        enc0.alpha = 8'd0;
        for (int c = 0; c < 4; c++)
        begin
            rnd = {1'b0, s3_prod_reg[c]} + (PROD_W + 1)'(1 << 23);
            m   = rnd[PROD_W:24];
            m16 = (m > (PROD_W - 23)'(16'hFFFF)) ? 16'hFFFF : m[15:0];
            if (c < 3)
            begin
                enc0.lv[c]   = {m16[15:4], 1'b1, 17'd0};
                enc0.code[c] = 8'd0;
                enc0.lin[c]  = (m > (PROD_W - 23)'(255)) ? 8'hFF : m[7:0];
            end
            else
            begin
                enc0.alpha = (m > (PROD_W - 23)'(255)) ? 8'hFF : m[7:0];
            end
        end
    end

    // one code bit per stage, most significant first
    always_comb
    begin
        logic [7:0] cand;
        for (int k = 0; k < ENC_STAGES; k++)
        begin
            enc_next[k+1] = enc_reg[k];
            for (int c = 0; c < 3; c++)
            begin
                cand = enc_reg[k].code[c] | (8'h80 >> k);
                if (THR_TAB[cand] <= {1'b0, enc_reg[k].lv[c]})
                    enc_next[k+1].code[c] = cand;
            end
        end
    end

    always_comb
    begin
        enc_t e;
        e = enc_reg[ENC_STAGES];
        push_item.red_out       = e.mode ? e.code[0] : e.lin[0];
        push_item.green_out     = e.mode ? e.code[1] : e.lin[1];
        push_item.blue_out      = e.mode ? e.code[2] : e.lin[2];
        push_item.alpha_out     = e.alpha;
        push_item.last_of_level = e.last;
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= q_item;
        wb_slot_reg <= s1_reg.slot;
        wb_data_reg <= acc_entry;
        s2_sums_reg <= acc_entry;
        s2_cnt_reg  <= s1_reg.cnt;
        s2_mode_reg <= s1_reg.mode;
        s2_last_reg <= s1_reg.level_end;
        for (int c = 0; c < 3; c++)
            s3_prod_reg[c] <= PROD_W'(s2_sums_reg.color[c] * RECIP_TAB[s2_cnt_reg]);
        s3_prod_reg[3] <= PROD_W'(s2_sums_reg.alpha * RECIP_TAB[s2_cnt_reg]);
        s3_mode_reg    <= s2_mode_reg;
        s3_last_reg    <= s2_last_reg;
        if (fifo_push)
            fifo_reg[fwp_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int k = 0; k <= ENC_STAGES; k++)
                enc_reg[k].valid <= 1'b0;
            fwp_reg  <= '0;
            frp_reg  <= '0;
            fcnt_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= q_rd;
            wb_valid_reg <= s1_valid_reg;
            s2_valid_reg <= s1_valid_reg && s1_reg.last;
            s3_valid_reg <= s2_valid_reg;
            enc_reg[0]   <= enc0;
            for (int k = 1; k <= ENC_STAGES; k++)
                enc_reg[k] <= enc_next[k];
            if (fifo_push)
                fwp_reg <= fwp_reg + OPTR_W'(1);
            if (fifo_pop)
                frp_reg <= frp_reg + OPTR_W'(1);
            fcnt_reg <= fcnt_reg + (OPTR_W + 1)'(fifo_push) - (OPTR_W + 1)'(fifo_pop);
            res_reg  <= res_reg + RES_W'(q_rd) - RES_W'(drop) - RES_W'(fifo_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) res_reg <= RES_W'(OUT_DEPTH))
        else $error("credit count overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_push && fcnt_reg == (OPTR_W + 1)'(OUT_DEPTH)))
        else $error("result fifo overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (OPTR_W + 1)'(fcnt_reg) <= (OPTR_W + 1)'(res_reg))
        else $error("fifo holds items without credit");

endmodule

// File: rtl/srgb_box_mip_downsampler.sv
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------------
// pixel in  | push / full          | in_item  (red/green/blue/alpha_in)
// result    | pop / empty          | out_item (rgba_out, last_of_level)
// config    | wr_en (no wait)      | wr_index, wr_data
//
// One pixel per clock is accepted while full is low; the line-buffer
// read-modify-write in the back end takes one item per cycle while credit
// remains, with a write bypass. The pixel that ends a span sends its result
// to the ports through the queue, accumulate, sum register, multiply, mean,
// eight encode search stages and fifo write. Reset clears counters, queue
// and fifo; the line buffer needs no clearing. Stalls on pop back up through
// a 16-item credit count into the 4-entry queue and then to full.
module srgb_box_mip_downsampler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [sbmd_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [sbmd_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            push,
    output logic                            full,
    input  sbmd_pkg::in_item_t              in_item,
    output logic                            empty,
    input  logic                            pop,
    output sbmd_pkg::out_item_t             out_item
);
    import sbmd_pkg::*;

    mid_item_t wr_item, rd_item;
    logic      q_wr, q_rd, q_empty;

    // front: config, raster counters, span classification, sRGB decode
    sbmd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .in_item  (in_item),
        .q_full   (full),
        .q_wr     (q_wr),
        .q_item   (wr_item)
    );

    sbmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_item (wr_item),
        .full    (full),
        .rd_en   (q_rd),
        .rd_item (rd_item),
        .empty   (q_empty)
    );

    // back: line buffer, averaging, encode, result fifo
    sbmd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (rd_item),
        .q_rd     (q_rd),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

// File: sim/sbmd_checker.sv
module sbmd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [sbmd_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [sbmd_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            push,
    input  logic                            full,
    input  sbmd_pkg::in_item_t              in_item,
    input  logic                            empty,
    input  logic                            pop,
    input  sbmd_pkg::out_item_t             out_item,
    output int                              errors,
    output int                              pending
);
    import sbmd_pkg::*;

    logic [15:0] to_linear [256];
    logic [30:0] level_step [256];
    logic [7:0]  to_srgb [4096];
    logic [24:0] inv_count [10];

    logic [12:0] cfg_w;
    logic [12:0] cfg_h;
    logic        cfg_srgb;

    logic [19:0] col_sum [LINE_DEPTH][3];
    logic [11:0] col_alpha [LINE_DEPTH];
    int unsigned src_x;
    int unsigned src_y;
    int unsigned dst_x;
    int unsigned dst_y;

    out_item_t   mip_expected [$];

    function automatic logic [63:0] pow5(input logic [63:0] y);
        logic [63:0] p;
        p = y;
        for (int k = 0; k < 4; k++)
        begin
            p = (p * y) >> 30;
        end
        return p;
    endfunction

    // sRGB code h/510 to linear light, Q2.30
    function automatic logic [63:0] srgb_half_to_lin(input int unsigned h);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] root;
        logic [63:0] cand;
        if (h <= 20)
        begin
            t = 64'(h * 10) << 30;
            return (t * 2 + 64'd65892) / 64'd131784;
        end
        t = ((64'(h * 1000 + 28050) << 30) + 64'd269025) / 64'd538050;
        if (t > (64'd1 << 30))
        begin
            t = 64'd1 << 30;
        end
        t2 = (t * t) >> 30;
        root = 0;
        for (int b = 30; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (cand <= (64'd1 << 30) && pow5(cand) <= t2)
            begin
                root = cand;
            end
        end
        return (t2 * root) >> 30;
    endfunction

    function automatic logic [63:0] rounded_mean(input logic [63:0] sum, input int cnt);
        return (sum * inv_count[cnt] + (64'd1 << 23)) >> 24;
    endfunction

    function automatic int unsigned fit_size(input logic [12:0] v, input int unsigned top);
        if (v == 0)
        begin
            return 1;
        end
        return (v > top) ? top : v;
    endfunction

    initial
    begin
        logic [63:0] q;
        logic [63:0] lv;
        int          b;
        for (int v = 0; v < 256; v++)
        begin
            q = (srgb_half_to_lin(2 * v) + 64'd8192) >> 14;
            to_linear[v] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
            level_step[v] = (v == 0) ? '0 : 31'(srgb_half_to_lin(2 * v - 1));
        end
        b = 0;
        for (int i = 0; i < 4096; i++)
        begin
            lv = 64'(2 * i + 1) << 17;
            while (b < 255 && level_step[b + 1] <= lv)
            begin
                b++;
            end
            to_srgb[i] = 8'(b);
        end
        inv_count[0] = '0;
        for (int n = 1; n < 10; n++)
        begin
            inv_count[n] = 25'(((1 << 24) + n / 2) / n);
        end
    end

    task automatic restart_level();
        src_x = 0;
        src_y = 0;
        dst_x = 0;
        dst_y = 0;
    endtask

    // one accepted source pixel: accumulate and maybe finish an output pixel
    task automatic take_pixel(input in_item_t px);
        int unsigned w;
        int unsigned h;
        int unsigned ow;
        int unsigned oh;
        int unsigned xb;
        int unsigned xe;
        int unsigned yb;
        int unsigned ye;
        int unsigned slot;
        int unsigned cnt;
        logic [7:0]  bytes [3];
        logic [19:0] sample;
        logic [63:0] m;
        out_item_t   res;
        w  = fit_size(cfg_w, MAX_WIDTH);
        h  = fit_size(cfg_h, MAX_HEIGHT);
        ow = (w / 2 != 0) ? w / 2 : 1;
        oh = (h / 2 != 0) ? h / 2 : 1;
        xb = dst_x * w / ow;
        xe = (dst_x + 1) * w / ow;
        yb = dst_y * h / oh;
        ye = (dst_y + 1) * h / oh;
        slot = (dst_x < LINE_DEPTH) ? dst_x : LINE_DEPTH - 1;
        bytes[0] = px.red_in;
        bytes[1] = px.green_in;
        bytes[2] = px.blue_in;
        for (int ch = 0; ch < 3; ch++)
        begin
            sample = cfg_srgb ? 20'(to_linear[bytes[ch]]) : 20'(bytes[ch]);
            if (src_x == xb && src_y == yb)
                col_sum[slot][ch] = sample;
            else
                col_sum[slot][ch] = col_sum[slot][ch] + sample;
        end
        if (src_x == xb && src_y == yb)
            col_alpha[slot] = 12'(px.alpha_in);
        else
            col_alpha[slot] = col_alpha[slot] + 12'(px.alpha_in);

        if (src_x + 1 == xe && src_y + 1 == ye)
        begin
            cnt = (xe - xb) * (ye - yb);
            if (cnt > 9) cnt = 9;
            if (cnt == 0) cnt = 1;
            for (int ch = 0; ch < 3; ch++)
            begin
                m = rounded_mean(64'(col_sum[slot][ch]), cnt);
                if (cfg_srgb)
                    bytes[ch] = to_srgb[((m > 64'd65535) ? 64'd65535 : m) >> 4];
                else
                    bytes[ch] = (m > 64'd255) ? 8'd255 : m[7:0];
            end
            m = rounded_mean(64'(col_alpha[slot]), cnt);
            res.red_out       = bytes[0];
            res.green_out     = bytes[1];
            res.blue_out      = bytes[2];
            res.alpha_out     = (m > 64'd255) ? 8'd255 : m[7:0];
            res.last_of_level = (dst_x + 1 == ow && dst_y + 1 == oh);
            mip_expected.insert(mip_expected.size(), res);
        end

        src_x++;
        if (src_x >= xe) dst_x++;
        if (src_x >= w)
        begin
            src_x = 0;
            dst_x = 0;
            src_y++;
            if (src_y >= ye) dst_y++;
            if (src_y >= h) restart_level();
        end
    endtask

    function automatic int field_bad(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (mip_expected.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = mip_expected.pop_front();
        errors += field_bad("red_out", want.red_out, got.red_out);
        errors += field_bad("green_out", want.green_out, got.green_out);
        errors += field_bad("blue_out", want.blue_out, got.blue_out);
        errors += field_bad("alpha_out", want.alpha_out, got.alpha_out);
        errors += field_bad("last_of_level", want.last_of_level, got.last_of_level);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w    = 13'd1;
            cfg_h    = 13'd1;
            cfg_srgb = 1'b0;
            restart_level();
            mip_expected.delete();
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_SOURCE_WIDTH:  begin cfg_w = wr_data; restart_level(); end
                    REG_SOURCE_HEIGHT: begin cfg_h = wr_data; restart_level(); end
                    REG_SRGB_MODE:     begin cfg_srgb = wr_data[0]; restart_level(); end
                    default: ;
                endcase
            end
            if (push && !full)
                take_pixel(in_item);
            if (pop && !empty)
                check_result(out_item);
        end
        pending = mip_expected.size();
    end

endmodule

// File: sim/tb_srgb_box_mip_downsampler.sv
// Stimulus and verdict for the sRGB box-filter mip downsampler. Prediction and
// comparison live in sbmd_checker, which watches every channel.
module tb_srgb_box_mip_downsampler;
    import sbmd_pkg::*;

    // index past the last register; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // drain allowance for the pipeline; an item may finish no span
    localparam int DRAIN_CYCLES = 64;
    // pixels fed at the start of the widest row and the tallest column
    localparam int EDGE_ITEMS   = 100;
    // pixels fed over random levels
    localparam int RANDOM_ITEMS = 1000;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    logic                  push;
    logic                  full;
    in_item_t              in_item;
    logic                  empty;
    logic                  pop;
    out_item_t             out_item;
    int                    errors;
    int                    pending;

    bit                    quiet;    // when set neither side idles
    int                    fed;      // source pixels accepted through feed

    srgb_box_mip_downsampler i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    sbmd_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop; well beyond the slowest legal run
    initial
    begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end

    // result side: pop held low about 36% of cycles unless in a quiet stretch
    always @(posedge clk)
    begin
        pop <= quiet || ($urandom_range(99) >= 36);
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_pixel();
        in_item_t px;
        px.red_in   = pick_byte();
        px.green_in = pick_byte();
        px.blue_in  = pick_byte();
        px.alpha_in = pick_byte();
        return px;
    endfunction

    // one pixel; called just after the clock rises, returns after acceptance
    task automatic send_pixel(input in_item_t px);
        while (!quiet && $urandom_range(99) < 36)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= px;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // lower push, let every expected item out, then let the pipe drain
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all three registers back to back; block must be idle
    task automatic set_level(input int w, input int h, input bit srgb);
        wr_en    <= 1'b1;
        wr_index <= REG_SOURCE_WIDTH;
        wr_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        wr_index <= REG_SOURCE_HEIGHT;
        wr_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        wr_index <= REG_SRGB_MODE;
        wr_data  <= CFG_DATA_W'(srgb);
        @(posedge clk);
        if ($urandom_range(3) == 0)
        begin
            wr_index <= REG_UNUSED;
            wr_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic feed(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_pixel(random_pixel());
            fed++;
            quiet = (fed >= 400 && fed < 700);
        end
    endtask

    initial
    begin
        in_item_t px;
        int       w;
        int       h;
        int       n;
        quiet    = 1'b0;
        fed      = 0;
        rst_n    = 1'b0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        push     = 1'b0;
        in_item  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size is 1x1: every pixel is its own output and ends the level
        for (int i = 0; i < 3; i++)
        begin
            px = (i == 0) ? '0 : (i == 1) ? '1 : {8'hAA, 8'h55, 8'h01, 8'hFE};
            send_pixel(px);
        end
        settle();

        // 1x1 in linear light: extremes and alternating bit patterns
        set_level(1, 1, 1'b1);
        send_pixel('0);
        send_pixel('1);
        send_pixel({8'h55, 8'hAA, 8'h80, 8'h7F});
        send_pixel({8'h01, 8'hFE, 8'h0A, 8'hAA});
        settle();

        // 3x3: one span of nine samples, all full scale
        set_level(3, 3, 1'b0);
        repeat (9) send_pixel('1);
        settle();

        // zero size counts as one; 3x2 sRGB gives a single 3x2 span
        set_level(0, 0, 1'b1);
        send_pixel({8'hFF, 8'h00, 8'hFF, 8'h00});
        settle();
        set_level(3, 2, 1'b1);
        repeat (6) send_pixel({8'h00, 8'hFF, 8'h00, 8'hFF});
        settle();

        // start of the widest row with saturating width, then of the tallest column
        set_level(8191, 1, 1'b1);
        feed(EDGE_ITEMS);
        settle();
        set_level(1, MAX_HEIGHT, 1'b0);
        feed(EDGE_ITEMS);
        settle();

        // random levels, mostly small; a few broken off mid-level
        fed = 0;
        while (fed < RANDOM_ITEMS)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            h = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
            set_level(w, h, $urandom_range(1));
            n = w * h * $urandom_range(1, 3);
            if ($urandom_range(7) == 0)
                n = $urandom_range(1, w * h);
            if (n > RANDOM_ITEMS - fed)
                n = RANDOM_ITEMS - fed;
            feed(n);
            settle();
        end

        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
